@@ sv/sliding_median_spike_detector_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sliding median spike detector
// Immediate-implication and next-cycle-implication checks on a clock.
// ----------------------------------------------------------------------------
`ifndef SLIDING_MEDIAN_SPIKE_DETECTOR_TOP_ASSERT_SVH
`define SLIDING_MEDIAN_SPIKE_DETECTOR_TOP_ASSERT_SVH

// check cons in the same cycle as ante
`define SMSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define SMSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/smsd_pkg.sv @@
// ----------------------------------------------------------------------------
// smsd_pkg
// Shared constants and cell operation codes of the spike detector.
// ----------------------------------------------------------------------------
`default_nettype none

package smsd_pkg;

    localparam int WINDOW_MAX_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_BITS        = 9;
    localparam int COUNT_BITS      = 32;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_ROTATE,
        CELL_DELETE,
        CELL_INSERT
    } t_cell_op;

endpackage

`default_nettype wire

@@ sv/smsd_if.sv @@
// ----------------------------------------------------------------------------
// smsd_if
// Valid/ready channels for sample beats in and result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface smsd_in_if #(
    parameter int SAMPLE_BITS = smsd_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic                   series_start;

    modport source (output valid, sample_value, series_start, input ready);
    modport sink   (input valid, sample_value, series_start, output ready);
endinterface

interface smsd_out_if #(
    parameter int SAMPLE_BITS = smsd_pkg::SAMPLE_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic                            notify;
    logic                            window_full;
    logic [SAMPLE_BITS:0]            median_doubled;
    logic [smsd_pkg::COUNT_BITS-1:0] notification_total;

    modport source (output valid, notify, window_full, median_doubled, notification_total,
                    input ready);
    modport sink   (input valid, notify, window_full, median_doubled, notification_total,
                    output ready);
endinterface

`default_nettype wire

@@ sv/smsd_cell.sv @@
// ----------------------------------------------------------------------------
// smsd_cell
// One slot of the sorted sample chain: value, age and stale flag, with
// clear, rotate, delete-shift and sorted-insert moves between neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module smsd_cell #(
    parameter int  WINDOW_MAX  = smsd_pkg::WINDOW_MAX_DEF,
    parameter int  SAMPLE_BITS = smsd_pkg::SAMPLE_BITS_DEF,
    localparam int AW          = $clog2(WINDOW_MAX)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire smsd_pkg::t_cell_op     i_op,
    input  wire logic [SAMPLE_BITS-1:0] i_new_value,
    input  wire logic [SAMPLE_BITS-1:0] i_del_value,
    input  wire logic [SAMPLE_BITS-1:0] i_up_value,
    input  wire logic [AW-1:0]          i_up_age,
    input  wire logic                   i_up_stale,
    input  wire logic [SAMPLE_BITS-1:0] i_dn_value,
    input  wire logic [AW-1:0]          i_dn_age,
    input  wire logic                   i_dn_stale,
    input  wire logic                   i_dn_lt,
    output logic [SAMPLE_BITS-1:0]      o_value,
    output logic [AW-1:0]               o_age,
    output logic                        o_stale,
    output logic                        o_lt
);
    import smsd_pkg::*;

    logic [SAMPLE_BITS-1:0] r_value, n_value;
    logic [AW-1:0]          r_age, n_age;
    logic                   r_stale, n_stale;
    logic                   ge_del;

    assign o_lt   = r_stale || (i_new_value <= r_value);
    assign ge_del = r_stale || (r_value > i_del_value) ||
                    ((r_value == i_del_value) && (r_age == AW'(WINDOW_MAX - 1)));

    always_comb begin
        n_value = r_value;
        n_age   = r_age;
        n_stale = r_stale;
        unique case (i_op)
            CELL_HOLD: begin
            end
            CELL_CLEAR: begin
                n_stale = 1'b1;
            end
            CELL_ROTATE: begin
                n_value = i_up_value;
                n_age   = i_up_age;
                n_stale = i_up_stale;
            end
            CELL_DELETE: begin
                if (ge_del) begin
                    n_value = i_up_value;
                    n_age   = i_up_age;
                    n_stale = i_up_stale;
                end
            end
            CELL_INSERT: begin
                if (i_dn_lt) begin
                    n_value = i_dn_value;
                    n_age   = i_dn_age + AW'(1);
                    n_stale = i_dn_stale;
                end else if (o_lt) begin
                    n_value = i_new_value;
                    n_age   = '0;
                    n_stale = 1'b0;
                end else if (!r_stale) begin
                    n_age   = r_age + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale <= 1'b1;
        end else begin
            r_stale <= n_stale;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_age   <= n_age;
    end

    assign o_value = r_value;
    assign o_age   = r_age;
    assign o_stale = r_stale;

endmodule

`default_nettype wire

@@ sv/smsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// smsd_ctrl
// Sequencer: takes sample beats, rotates the chain past the head to rank the
// trailing window, drives delete and insert, forms and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_median_spike_detector_top_assert.svh"

module smsd_ctrl #(
    parameter int  WINDOW_MAX  = smsd_pkg::WINDOW_MAX_DEF,
    parameter int  SAMPLE_BITS = smsd_pkg::SAMPLE_BITS_DEF,
    localparam int AW          = $clog2(WINDOW_MAX)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [smsd_pkg::CFG_BITS-1:0] i_cfg_data,
    smsd_in_if.sink                            i_in,
    smsd_out_if.source                         o_out,
    input  wire logic [SAMPLE_BITS-1:0]        i_head_value,
    input  wire logic [AW-1:0]                 i_head_age,
    input  wire logic                          i_head_stale,
    output smsd_pkg::t_cell_op                 o_cell_op,
    output logic [SAMPLE_BITS-1:0]             o_new_value,
    output logic [SAMPLE_BITS-1:0]             o_del_value
);
    import smsd_pkg::*;

    localparam int LW = $clog2(WINDOW_MAX + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DELETE,
        S_INSERT,
        S_POST
    } t_state;

    t_state                 r_state;
    logic [CFG_BITS-1:0]    r_window_length;
    logic [AW-1:0]          r_scan;
    logic [LW-1:0]          r_cnt;
    logic [LW-1:0]          r_len;
    logic [LW-1:0]          r_held;
    logic [COUNT_BITS-1:0]  r_count;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SAMPLE_BITS-1:0] r_lo;
    logic [SAMPLE_BITS-1:0] r_hi;
    logic [SAMPLE_BITS-1:0] r_del_value;
    logic                   r_del_seen;
    logic                   r_res_note;
    logic                   r_res_full;
    logic [SAMPLE_BITS:0]   r_res_doubled;
    logic                   r_out_valid;
    logic                   r_out_note;
    logic                   r_out_full;
    logic [SAMPLE_BITS:0]   r_out_doubled;
    logic [COUNT_BITS-1:0]  r_out_total;

    logic                   in_accept;
    logic [LW-1:0]          len_eff;
    logic [LW-1:0]          lo_rank;
    logic [LW-1:0]          hi_rank;
    logic                   head_in_window;
    logic                   head_oldest;
    logic                   full;
    logic [SAMPLE_BITS:0]   doubled;
    logic                   note;
    logic                   out_load;
    logic                   in_delete;
    logic                   scan_last;
    logic [LW-1:0]          win_count;
    logic                   out_idle;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_accept  = i_in.valid && i_in.ready;

    always_comb begin
        if (r_window_length == '0) begin
            len_eff = LW'(1);
        end else if (int'(r_window_length) > WINDOW_MAX) begin
            len_eff = LW'(WINDOW_MAX);
        end else begin
            len_eff = LW'(r_window_length);
        end
    end

    assign lo_rank        = (r_len - LW'(1)) >> 1;
    assign hi_rank        = r_len >> 1;
    assign head_in_window = !i_head_stale && (LW'(i_head_age) < r_len);
    assign head_oldest    = !i_head_stale && (i_head_age == AW'(WINDOW_MAX - 1));

    assign full    = (r_held >= r_len);
    assign doubled = full ? ({1'b0, r_lo} + {1'b0, r_hi}) : '0;
    assign note    = full && ({1'b0, r_sample} >= doubled);

    assign out_load  = (r_state == S_POST) && (!r_out_valid || o_out.ready);
    assign in_delete = (r_state == S_DELETE);
    assign scan_last = (r_state == S_SCAN) && (r_scan == AW'(WINDOW_MAX - 1));
    assign win_count = (r_held < r_len) ? r_held : r_len;
    assign out_idle  = !r_out_valid && (r_state != S_POST);

    always_comb begin
        unique case (r_state)
            S_IDLE:   o_cell_op = (in_accept && i_in.series_start) ? CELL_CLEAR : CELL_HOLD;
            S_SCAN:   o_cell_op = CELL_ROTATE;
            S_DELETE: o_cell_op = CELL_DELETE;
            S_INSERT: o_cell_op = CELL_INSERT;
            S_POST:   o_cell_op = CELL_HOLD;
            default:  o_cell_op = CELL_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_window_length <= CFG_BITS'(1);
            r_held          <= '0;
            r_count         <= '0;
            r_out_valid     <= 1'b0;
            r_del_seen      <= 1'b0;
            r_scan          <= '0;
            r_cnt           <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window_length <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_sample   <= i_in.sample_value;
                        r_len      <= len_eff;
                        r_scan     <= '0;
                        r_cnt      <= '0;
                        r_del_seen <= 1'b0;
                        if (i_in.series_start) begin
                            r_held  <= '0;
                            r_count <= '0;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (head_in_window) begin
                        if (r_cnt == lo_rank) begin
                            r_lo <= i_head_value;
                        end
                        if (r_cnt == hi_rank) begin
                            r_hi <= i_head_value;
                        end
                        r_cnt <= r_cnt + LW'(1);
                    end
                    if (head_oldest) begin
                        r_del_value <= i_head_value;
                        r_del_seen  <= 1'b1;
                    end
                    if (r_scan == AW'(WINDOW_MAX - 1)) begin
                        r_state <= (r_held == LW'(WINDOW_MAX)) ? S_DELETE : S_INSERT;
                    end else begin
                        r_scan <= r_scan + AW'(1);
                    end
                end
                S_DELETE: begin
                    r_state <= S_INSERT;
                end
                S_INSERT: begin
                    r_res_note    <= note;
                    r_res_full    <= full;
                    r_res_doubled <= doubled;
                    if (note && (r_count != '1)) begin
                        r_count <= r_count + COUNT_BITS'(1);
                    end
                    if (r_held != LW'(WINDOW_MAX)) begin
                        r_held <= r_held + LW'(1);
                    end
                    r_state <= S_POST;
                end
                S_POST: begin
                    if (out_load) begin
                        r_out_note    <= r_res_note;
                        r_out_full    <= r_res_full;
                        r_out_doubled <= r_res_doubled;
                        r_out_total   <= r_count;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.notify             = r_out_note;
    assign o_out.window_full        = r_out_full;
    assign o_out.median_doubled     = r_out_doubled;
    assign o_out.notification_total = r_out_total;

    assign o_new_value = r_sample;
    assign o_del_value = r_del_value;

    `SMSD_ASSERT_IMPL(a_delete_has_victim, i_clk, i_rst_n, in_delete, r_del_seen, "no victim")
    `SMSD_ASSERT_NEXT(a_scan_count, i_clk, i_rst_n, scan_last, r_cnt == win_count, "bad count")
    `SMSD_ASSERT_NEXT(a_out_from_post, i_clk, i_rst_n, out_idle, !r_out_valid, "stray beat")

endmodule

`default_nettype wire

@@ sv/sliding_median_spike_detector_top.sv @@
// ----------------------------------------------------------------------------
// sliding_median_spike_detector_top
// Flags a sample that reaches twice the median of the trailing window.
//
// i_in carries one sample beat (sample_value, series_start); o_out carries
// one result beat per sample (notify, window_full, median_doubled,
// notification_total). i_cfg_we/i_cfg_data write window_length while idle.
// Samples sit in a chain of WINDOW_MAX cells kept sorted by value and age.
// Each sample rotates the whole chain once past the head to rank the window,
// then, once WINDOW_MAX samples are held, shifts out the oldest sample, and
// inserts the new one in place. A new sample is taken only when the last one
// has been handed to the output register. The result beat is registered
// after the rotation, the delete step when the oldest sample is dropped,
// and the insert step.
// Reset marks every cell stale, clears counts and sets window_length to 1.
// A stalled result holds in the output register; the next sample is still
// taken and processed, then waits until the held beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_median_spike_detector_top #(
    parameter int WINDOW_MAX  = smsd_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = smsd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [smsd_pkg::CFG_BITS-1:0] i_cfg_data,
    smsd_in_if.sink                            i_in,
    smsd_out_if.source                         o_out
);
    import smsd_pkg::*;

    localparam int AW = $clog2(WINDOW_MAX);

    t_cell_op               cell_op;
    logic [SAMPLE_BITS-1:0] new_value;
    logic [SAMPLE_BITS-1:0] del_value;
    logic                   top_up_stale;

    logic [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];
    logic [AW-1:0]          cell_age   [WINDOW_MAX];
    logic                   cell_stale [WINDOW_MAX];
    logic                   cell_lt    [WINDOW_MAX];

    assign top_up_stale = (cell_op == CELL_DELETE) || cell_stale[0];

    smsd_ctrl #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in         (i_in),
        .o_out        (o_out),
        .i_head_value (cell_value[0]),
        .i_head_age   (cell_age[0]),
        .i_head_stale (cell_stale[0]),
        .o_cell_op    (cell_op),
        .o_new_value  (new_value),
        .o_del_value  (del_value)
    );

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        logic [SAMPLE_BITS-1:0] up_value;
        logic [AW-1:0]          up_age;
        logic                   up_stale;
        logic [SAMPLE_BITS-1:0] dn_value;
        logic [AW-1:0]          dn_age;
        logic                   dn_stale;
        logic                   dn_lt;

        if (g == WINDOW_MAX - 1) begin : g_up_wrap
            assign up_value = cell_value[0];
            assign up_age   = cell_age[0];
            assign up_stale = top_up_stale;
        end else begin : g_up_next
            assign up_value = cell_value[g+1];
            assign up_age   = cell_age[g+1];
            assign up_stale = cell_stale[g+1];
        end

        if (g == 0) begin : g_dn_floor
            assign dn_value = cell_value[0];
            assign dn_age   = cell_age[0];
            assign dn_stale = 1'b1;
            assign dn_lt    = 1'b0;
        end else begin : g_dn_prev
            assign dn_value = cell_value[g-1];
            assign dn_age   = cell_age[g-1];
            assign dn_stale = cell_stale[g-1];
            assign dn_lt    = cell_lt[g-1];
        end

        smsd_cell #(
            .WINDOW_MAX  (WINDOW_MAX),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_op        (cell_op),
            .i_new_value (new_value),
            .i_del_value (del_value),
            .i_up_value  (up_value),
            .i_up_age    (up_age),
            .i_up_stale  (up_stale),
            .i_dn_value  (dn_value),
            .i_dn_age    (dn_age),
            .i_dn_stale  (dn_stale),
            .i_dn_lt     (dn_lt),
            .o_value     (cell_value[g]),
            .o_age       (cell_age[g]),
            .o_stale     (cell_stale[g]),
            .o_lt        (cell_lt[g])
        );
    end

endmodule

`default_nettype wire

@@ verif/tb_sliding_median_spike_detector_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_median_spike_detector_top
// Drives sample beats and window_length writes into the spike detector and
// checks every result beat against an in-bench predictor. The predictor keeps
// its own ring of samples and ranks the trailing window once it is full. The
// test runs directed series first, then randomized series over many window
// lengths, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sliding_median_spike_detector_top;
    import smsd_pkg::*;

    localparam int WMAX  = WINDOW_MAX_DEF;
    localparam int SBITS = SAMPLE_BITS_DEF;
    localparam logic [SBITS-1:0] SAMPLE_TOP = '1;

    typedef struct packed {
        logic                  notify;
        logic                  window_full;
        logic [SBITS:0]        median_doubled;
        logic [COUNT_BITS-1:0] notification_total;
    } t_spike_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_BITS-1:0] i_cfg_data;

    smsd_in_if  #(.SAMPLE_BITS(SBITS)) in_bus ();
    smsd_out_if #(.SAMPLE_BITS(SBITS)) out_bus ();

    sliding_median_spike_detector_top #(
        .WINDOW_MAX (WMAX),
        .SAMPLE_BITS(SBITS)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_bus),
        .o_out     (out_bus)
    );

    // predictor state
    logic [SBITS-1:0]      sample_ring [WMAX];
    int                    ring_head;
    int                    ring_fill;
    logic [COUNT_BITS-1:0] spike_total;
    logic [CFG_BITS-1:0]   window_len_cfg;

    t_spike_result pending_results [$];

    int  fail_count;
    int  samples_sent;
    int  results_seen;
    int  full_seen;
    int  notices_seen;
    bit  no_idle;
    int  stall_left = 0;
    int  base_level;
    int  spread;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 24);
        end else if (r < 99) begin
            return $urandom_range(25, 80);
        end
        return $urandom_range(100, 300);
    endfunction

    function automatic int effective_span();
        if (window_len_cfg == 0) begin
            return 1;
        end else if (window_len_cfg > WMAX) begin
            return WMAX;
        end
        return int'(window_len_cfg);
    endfunction

    function automatic logic [SBITS:0] trailing_median_x2(input int span);
        logic [SBITS-1:0] ranked [WMAX];
        logic [SBITS-1:0] v;
        int               i;
        int               j;
        for (i = 0; i < span; i++) begin
            v = sample_ring[(ring_head + WMAX - 1 - i) % WMAX];
            j = i;
            while (j > 0 && ranked[j-1] > v) begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = v;
        end
        if (span % 2 == 1) begin
            return {ranked[span/2], 1'b0};
        end
        return {1'b0, ranked[span/2-1]} + {1'b0, ranked[span/2]};
    endfunction

    function automatic t_spike_result apply_sample(input logic [SBITS-1:0] value,
                                                   input logic start);
        t_spike_result r;
        int            span;
        if (start) begin
            ring_head   = 0;
            ring_fill   = 0;
            spike_total = '0;
        end
        span = effective_span();
        r.window_full    = (ring_fill >= span);
        r.notify         = 1'b0;
        r.median_doubled = '0;
        if (r.window_full) begin
            r.median_doubled = trailing_median_x2(span);
            if ({1'b0, value} >= r.median_doubled) begin
                r.notify = 1'b1;
                if (spike_total != '1) begin
                    spike_total = spike_total + 1'b1;
                end
            end
        end
        sample_ring[ring_head] = value;
        ring_head = (ring_head + 1) % WMAX;
        if (ring_fill < WMAX) begin
            ring_fill++;
        end
        r.notification_total = spike_total;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        fail_count++;
        if (fail_count <= 100) begin
            $display("%0t: result beat %0d %s: got %0d, expected %0d",
                     $time, results_seen, what, got, want);
        end
    endtask

    task automatic check_result();
        t_spike_result got;
        t_spike_result want;
        got.notify             = out_bus.notify;
        got.window_full        = out_bus.window_full;
        got.median_doubled     = out_bus.median_doubled;
        got.notification_total = out_bus.notification_total;
        results_seen++;
        if (got.window_full === 1'b1) full_seen++;
        if (got.notify === 1'b1) notices_seen++;
        if (pending_results.size() == 0) begin
            report_mismatch("beat with no sample pending", 0, 0);
        end else begin
            want = pending_results.pop_front();
            if (got.notify !== want.notify)
                report_mismatch("notify", got.notify, want.notify);
            if (got.window_full !== want.window_full)
                report_mismatch("window_full", got.window_full, want.window_full);
            if (got.median_doubled !== want.median_doubled)
                report_mismatch("median_doubled", got.median_doubled, want.median_doubled);
            if (got.notification_total !== want.notification_total)
                report_mismatch("notification_total", got.notification_total,
                                want.notification_total);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            check_result();
        end
        if (stall_left > 0) begin
            stall_left--;
        end else if (!no_idle && $urandom_range(3) == 0) begin
            stall_left = pick_gap();
        end
        out_bus.ready <= no_idle || stall_left == 0;
    end

    task automatic send_sample(input logic [SBITS-1:0] value, input logic start);
        int gap;
        gap = (no_idle || $urandom_range(2) != 0) ? 0 : pick_gap();
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid        <= 1'b1;
        in_bus.sample_value <= value;
        in_bus.series_start <= start;
        do @(posedge i_clk); while (!in_bus.ready);
        pending_results.push_back(apply_sample(value, start));
        samples_sent++;
    endtask

    task automatic drain();
        in_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [CFG_BITS-1:0] len);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        window_len_cfg = len;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_window_one();
        send_sample(16'd100, 1'b1);
        send_sample(16'd200, 1'b0);
        send_sample(16'd199, 1'b0);
        send_sample(SAMPLE_TOP, 1'b0);
        send_sample(SAMPLE_TOP, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd0, 1'b0);
    endtask

    task automatic test_even_window();
        set_window(9'd2);
        send_sample(16'd10, 1'b1);
        send_sample(16'd30, 1'b0);
        send_sample(16'd20, 1'b0);
        send_sample(16'd50, 1'b0);
        send_sample(SAMPLE_TOP, 1'b0);
        send_sample(SAMPLE_TOP, 1'b0);
        send_sample(SAMPLE_TOP, 1'b0);
    endtask

    // zero length acts as one; keep the series running across the write
    task automatic test_zero_length();
        set_window(9'd0);
        send_sample(16'd1, 1'b0);
        send_sample(16'd3, 1'b0);
    endtask

    task automatic test_odd_window();
        set_window(9'd3);
        send_sample(16'd5, 1'b1);
        send_sample(16'd1, 1'b0);
        send_sample(16'd9, 1'b0);
        send_sample(16'd10, 1'b0);
        send_sample(SAMPLE_TOP, 1'b1);
    endtask

    task automatic new_series_profile();
        case ($urandom_range(3))
            0: base_level = $urandom_range(0, 15);
            1: base_level = $urandom_range(0, 65535) >> $urandom_range(0, 15);
            2: base_level = $urandom_range(60000, 65535);
            default: base_level = $urandom_range(0, 65535);
        endcase
        spread = 1 << $urandom_range(0, 12);
    endtask

    function automatic logic [SBITS-1:0] pick_sample(input logic start);
        int             r;
        int             v;
        int             span;
        logic [SBITS:0] ref2;
        r    = $urandom_range(99);
        span = effective_span();
        if (r < 8) begin
            return SBITS'($urandom_range(0, 65535));
        end else if (r < 18 && !start && ring_fill >= span) begin
            ref2 = trailing_median_x2(span);
            v    = int'(ref2) - $urandom_range(0, 1);
        end else if (r < 32) begin
            v = 2 * base_level + $urandom_range(0, spread);
        end else begin
            v = base_level + $urandom_range(0, 2 * spread) - spread;
        end
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[SBITS-1:0];
    endfunction

    task automatic test_random_phases();
        int  lens  [21] = '{2, 3, 1, 4, 5, 8, 0, 7, 16, 17, 33, 64, 65,
                            256, 255, 511, 257, 6, 9, 2, 1};
        int  beats [21] = '{60, 60, 50, 60, 60, 60, 40, 60, 70, 70, 80, 120, 80,
                            300, 60, 300, 60, 60, 60, 60, 150};
        int  p;
        int  k;
        int  span;
        bit  fresh;
        logic start;
        for (p = 0; p < 21; p++) begin
            no_idle = (p % 6 == 4);
            set_window(lens[p][CFG_BITS-1:0]);
            span = effective_span();
            if (p == 13 || p == 15) begin
                fresh = 1'b1;
            end else if (p == 14 || p == 16) begin
                fresh = 1'b0;
            end else begin
                fresh = $urandom_range(1);
            end
            for (k = 0; k < beats[p]; k++) begin
                start = (k == 0 && fresh) || $urandom_range(4 * span + 39) == 0;
                if (start || k == 0) new_series_profile();
                send_sample(pick_sample(start), start);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_data          <= '0;
        in_bus.valid        <= 1'b0;
        in_bus.sample_value <= '0;
        in_bus.series_start <= 1'b0;
        fail_count     = 0;
        samples_sent   = 0;
        results_seen   = 0;
        full_seen      = 0;
        notices_seen   = 0;
        no_idle        = 1'b0;
        ring_head      = 0;
        ring_fill      = 0;
        spike_total    = '0;
        window_len_cfg = 9'd1;
        base_level     = 0;
        spread         = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_window_one();
        test_even_window();
        test_zero_length();
        test_odd_window();
        test_random_phases();

        drain();
        repeat (WMAX + 16) @(posedge i_clk);
        $display("%0d samples sent, %0d results checked, %0d with a full window, %0d flagged",
                 samples_sent, results_seen, full_seen, notices_seen);
        $display("window lengths 0 to 256 and over-range 257 and 511, %0d mismatches",
                 fail_count);
        if (fail_count == 0) begin
            $display("PASS sliding_median_spike_detector_top");
        end else begin
            $display("FAIL sliding_median_spike_detector_top");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("timeout with %0d results pending", pending_results.size());
        $display("FAIL sliding_median_spike_detector_top");
        $finish;
    end

endmodule

`default_nettype wire
